// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// File: rtl/sgp_pkg.sv
package sgp_pkg;

	localparam logic [2:0] KIND_DESC = 3'd0;
	localparam logic [2:0] KIND_PROP = 3'd1;
	localparam logic [2:0] KIND_PAY  = 3'd2;
	localparam logic [2:0] KIND_END  = 3'd3;
	localparam logic [2:0] KIND_ERR  = 3'd4;

	localparam logic [2:0] ERR_TYPE   = 3'd0;
	localparam logic [2:0] ERR_HDRCUT = 3'd1;
	localparam logic [2:0] ERR_OBJCUT = 3'd2;
	localparam logic [2:0] ERR_STATUS = 3'd3;
	localparam logic [2:0] ERR_OVF    = 3'd4;
	localparam logic [2:0] ERR_PROPS  = 3'd5;

	localparam logic [7:0]  PRIO_DEFAULT = 8'd128;
	localparam logic [61:0] PROP_MAX     = 62'd65535;
	localparam logic [61:0] STATUS_EOG   = 62'h3;
	localparam logic [61:0] STATUS_EOT   = 62'h4;
	localparam logic [1:0]  SG_ZERO      = 2'd0;
	localparam logic [1:0]  SG_FIRST     = 2'd1;
	localparam logic [1:0]  SG_EXPLICIT  = 2'd2;
	localparam logic [1:0]  SG_BAD       = 2'd3;

	typedef enum logic [10:0] {
		PH_TYPE      = 11'b000_0000_0001,
		PH_ALIAS     = 11'b000_0000_0010,
		PH_GROUP     = 11'b000_0000_0100,
		PH_SUBGROUP  = 11'b000_0000_1000,
		PH_PRIORITY  = 11'b000_0001_0000,
		PH_DELTA     = 11'b000_0010_0000,
		PH_PROPLEN   = 11'b000_0100_0000,
		PH_PROPBYTES = 11'b000_1000_0000,
		PH_PAYLEN    = 11'b001_0000_0000,
		PH_STATUS    = 11'b010_0000_0000,
		PH_PAYLOAD   = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [55:0] acc;
		logic [2:0]  vbl;
		logic [61:0] alias_id;
		logic [61:0] group;
		logic [63:0] subgroup;
		logic        sg_known;
		logic [1:0]  sg_mode;
		logic [7:0]  prio;
		logic        has_props;
		logic        gef;
		logic [63:0] prev_id;
		logic        prev_valid;
		logic [61:0] delta;
		logic [61:0] left;
		logic        props_seen;
		logic        closed;
		logic        prio_explicit;
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [61:0] alias_id;
		logic [61:0] group;
		logic [63:0] subgroup;
		logic [63:0] oid;
		logic [7:0]  prio;
		logic [1:0]  status;
		logic [61:0] plen;
		logic [7:0]  db;
		logic        last;
		logic [2:0]  err;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} push_t;

	function automatic state_t reset_state();
		state_t s;
		s = '{phase: PH_TYPE, acc: '0, vbl: '0, alias_id: '0, group: '0, subgroup: '0,
			sg_known: 1'b0, sg_mode: '0, prio: PRIO_DEFAULT, has_props: 1'b0, gef: 1'b0,
			prev_id: '0, prev_valid: 1'b0, delta: '0, left: '0, props_seen: 1'b0,
			closed: 1'b0, prio_explicit: 1'b0};
		return s;
	endfunction

endpackage

// File: rtl/sgp_front.sv
module sgp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           start_stream,
	input  logic           byte_valid,
	input  logic [7:0]     data_byte,
	input  logic           end_of_stream,
	output sgp_pkg::push_t push
);

	sgp_pkg::state_t st_q;
	sgp_pkg::state_t s;
	sgp_pkg::res_t   r0;
	sgp_pkg::res_t   r1;
	logic [1:0]      n;
	logic [61:0]     v;
	logic [2:0]      vbl_n;
	logic [61:0]     left_n;
	logic [64:0]     sum;
	logic            ovf;
	logic [63:0]     id;
	logic [1:0]      stv;
	logic            desc;
	sgp_pkg::res_t   tmp;

	always_comb begin
		s = st_q;
		if (start_stream) s = sgp_pkg::reset_state();
		r0 = '0;
		r1 = '0;
		tmp = '0;
		n = 2'd0;
		v = '0;
		vbl_n = '0;
		left_n = s.left - 62'd1;
		stv = 2'd0;
		desc = 1'b0;
		sum = {1'b0, s.prev_id} + {3'b0, s.delta} + 65'd1;
		ovf = s.prev_valid && ((s.prev_id == '1) || sum[64]);
		id = s.prev_valid ? sum[63:0] : {2'b0, s.delta};
		if (!s.closed && byte_valid) begin
			case (s.phase)
				sgp_pkg::PH_PRIORITY: begin
					s.prio = data_byte;
					s.phase = sgp_pkg::PH_DELTA;
				end
				sgp_pkg::PH_PROPBYTES: begin
					s.left = left_n;
					if (left_n == '0) s.phase = sgp_pkg::PH_PAYLEN;
					r0.kind = sgp_pkg::KIND_PROP;
					r0.db = data_byte;
					r0.last = (left_n == '0);
					n = 2'd1;
				end
				sgp_pkg::PH_PAYLOAD: begin
					s.left = left_n;
					if (left_n == '0) s.phase = sgp_pkg::PH_DELTA;
					r0.kind = sgp_pkg::KIND_PAY;
					r0.db = data_byte;
					r0.last = (left_n == '0);
					n = 2'd1;
				end
				default: begin
					if (s.vbl == '0) begin
						v = {56'b0, data_byte[5:0]};
						case (data_byte[7:6])
							2'd0: vbl_n = 3'd0;
							2'd1: vbl_n = 3'd1;
							2'd2: vbl_n = 3'd3;
							default: vbl_n = 3'd7;
						endcase
					end else begin
						v = {s.acc[53:0], data_byte};
						vbl_n = s.vbl - 3'd1;
					end
					s.vbl = vbl_n;
					s.acc = {2'b0, v[53:0]};
					if (vbl_n == '0) begin
						s.acc = '0;
						case (s.phase)
							sgp_pkg::PH_TYPE: begin
								if (v[61:6] != '0 || !v[4] || v[2:1] == sgp_pkg::SG_BAD) begin
									s.closed = 1'b1;
									r0.kind = sgp_pkg::KIND_ERR;
									r0.err = sgp_pkg::ERR_TYPE;
									n = 2'd1;
								end else begin
									s.sg_mode = v[2:1];
									s.has_props = v[0];
									s.gef = v[3];
									s.prio_explicit = !v[5];
									if (v[5]) s.prio = sgp_pkg::PRIO_DEFAULT;
									s.phase = sgp_pkg::PH_ALIAS;
								end
							end
							sgp_pkg::PH_ALIAS: begin
								s.alias_id = v;
								s.phase = sgp_pkg::PH_GROUP;
							end
							sgp_pkg::PH_GROUP: begin
								s.group = v;
								if (s.sg_mode == sgp_pkg::SG_EXPLICIT) begin
									s.phase = sgp_pkg::PH_SUBGROUP;
								end else begin
									if (s.sg_mode == sgp_pkg::SG_ZERO) begin
										s.subgroup = '0;
										s.sg_known = 1'b1;
									end
									s.phase = s.prio_explicit ? sgp_pkg::PH_PRIORITY
										: sgp_pkg::PH_DELTA;
								end
							end
							sgp_pkg::PH_SUBGROUP: begin
								s.subgroup = {2'b0, v};
								s.sg_known = 1'b1;
								s.phase = s.prio_explicit ? sgp_pkg::PH_PRIORITY
									: sgp_pkg::PH_DELTA;
							end
							sgp_pkg::PH_DELTA: begin
								s.delta = v;
								s.props_seen = 1'b0;
								s.phase = s.has_props ? sgp_pkg::PH_PROPLEN
									: sgp_pkg::PH_PAYLEN;
							end
							sgp_pkg::PH_PROPLEN: begin
								if (v > sgp_pkg::PROP_MAX) begin
									s.closed = 1'b1;
									r0.kind = sgp_pkg::KIND_ERR;
									r0.err = sgp_pkg::ERR_PROPS;
									n = 2'd1;
								end else begin
									s.props_seen = (v != '0);
									s.left = v;
									s.phase = (v != '0) ? sgp_pkg::PH_PROPBYTES
										: sgp_pkg::PH_PAYLEN;
								end
							end
							sgp_pkg::PH_PAYLEN: begin
								if (v == '0) begin
									s.phase = sgp_pkg::PH_STATUS;
								end else begin
									s.left = v;
									s.phase = sgp_pkg::PH_PAYLOAD;
									r0.plen = v;
									desc = 1'b1;
								end
							end
							sgp_pkg::PH_STATUS: begin
								if (v == '0) begin
									stv = 2'd0;
								end else if (v == sgp_pkg::STATUS_EOG) begin
									stv = 2'd1;
								end else begin
									stv = 2'd2;
								end
								if ((v != '0 && v != sgp_pkg::STATUS_EOG
									&& v != sgp_pkg::STATUS_EOT)
									|| (v != '0 && s.props_seen)) begin
									s.closed = 1'b1;
									r0.kind = sgp_pkg::KIND_ERR;
									r0.err = sgp_pkg::ERR_STATUS;
									n = 2'd1;
								end else begin
									s.phase = sgp_pkg::PH_DELTA;
									r0.status = stv;
									desc = 1'b1;
								end
							end
							default: begin
								s.closed = 1'b1;
								r0.kind = sgp_pkg::KIND_ERR;
								r0.err = sgp_pkg::ERR_TYPE;
								n = 2'd1;
							end
						endcase
					end
				end
			endcase
			if (desc) begin
				n = 2'd1;
				if (ovf) begin
					s.closed = 1'b1;
					r0 = '0;
					r0.kind = sgp_pkg::KIND_ERR;
					r0.err = sgp_pkg::ERR_OVF;
				end else begin
					s.prev_id = id;
					s.prev_valid = 1'b1;
					if (s.sg_mode == sgp_pkg::SG_FIRST && !s.sg_known) begin
						s.subgroup = id;
						s.sg_known = 1'b1;
					end
					r0.kind = sgp_pkg::KIND_DESC;
					r0.oid = id;
				end
			end
		end
		if (!s.closed && end_of_stream) begin
			s.closed = 1'b1;
			if (s.phase inside {sgp_pkg::PH_TYPE, sgp_pkg::PH_ALIAS, sgp_pkg::PH_GROUP,
				sgp_pkg::PH_SUBGROUP, sgp_pkg::PH_PRIORITY}) begin
				tmp.kind = sgp_pkg::KIND_ERR;
				tmp.err = sgp_pkg::ERR_HDRCUT;
			end else if (s.phase == sgp_pkg::PH_DELTA && s.vbl == '0) begin
				tmp.kind = sgp_pkg::KIND_END;
				tmp.status = {1'b0, s.gef};
			end else begin
				tmp.kind = sgp_pkg::KIND_ERR;
				tmp.err = sgp_pkg::ERR_OBJCUT;
			end
			if (n == 2'd0) begin
				r0 = tmp;
			end else begin
				r1 = tmp;
			end
			n = n + 2'd1;
		end
		r0.alias_id = s.alias_id;
		r0.group = s.group;
		r0.subgroup = s.subgroup;
		r0.prio = s.prio;
		r1.alias_id = s.alias_id;
		r1.group = s.group;
		r1.subgroup = s.subgroup;
		r1.prio = s.prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sgp_pkg::reset_state();
		end else if (fire) begin
			st_q <= s;
		end
	end

	assign push.cnt  = fire ? n : 2'd0;
	assign push.res0 = r0;
	assign push.res1 = r1;

endmodule

// File: rtl/sgp_queue.sv
module sgp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  sgp_pkg::push_t push,
	output logic           room,
	output logic [2:0]     level,
	output logic           out_valid,
	input  logic           out_ready,
	output sgp_pkg::res_t  head
);

	sgp_pkg::res_t mem_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;
	logic          pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign room      = (cnt_q <= 3'd2);
	assign level     = cnt_q;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.res0;
		if (push.cnt == 2'd2) mem_q[wr_q + 2'd1] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.cnt;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

endmodule

// File: rtl/subgroup_stream_object_parser.sv
// Subgroup stream parser.
// Slave channel s_axis carries one stream byte per transaction: tdata is the
// byte, tuser[0] starts a new stream (clears all state first), tuser[1] marks
// tdata as a real byte (0 with tlast 1 is a bare end), tlast ends the stream.
// Master channel m_axis carries results: tuser is the kind (descriptor,
// property byte, payload byte, stream end, error), tlast marks the final byte
// of a property or payload run, tdata packs the header and object fields.
// One byte is accepted every cycle while s_axis_tready is high. A result is
// registered in the queue before it shows on m_axis. The front parser decodes
// combinationally and writes up to two results into a four-entry queue;
// s_axis_tready is low while fewer than two queue slots are free, so a stalled
// receiver blocks the sender once three or four results wait. Reset empties the
// queue and returns the parser to the stream-type state. Errors and stream ends
// close the stream until the next start.
`include "assert_macros.svh"

module subgroup_stream_object_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic [1:0]   s_axis_tuser,   // start_stream, byte_valid
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// alias, group, subgroup, object number, priority, status,
	// payload size, data byte, error code, zero pad
	output logic [335:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast
);

	sgp_pkg::push_t push;
	sgp_pkg::res_t  head;
	logic           fire;
	logic [2:0]     level;

	assign fire = s_axis_tvalid && s_axis_tready;

	sgp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.start_stream  (s_axis_tuser[0]),
		.byte_valid    (s_axis_tuser[1]),
		.data_byte     (s_axis_tdata),
		.end_of_stream (s_axis_tlast),
		.push          (push)
	);

	sgp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_axis_tready),
		.level     (level),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = {1'b0, head.err, head.db, head.plen, head.status, head.prio,
		head.oid, head.subgroup, head.group, head.alias_id};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

	`ASSERT_NEVER(a_queue_bound, clk, arst_n, level > 3'd4)
	`ASSERT_NEVER(a_last_kind, clk, arst_n, m_axis_tvalid && m_axis_tlast && m_axis_tuser != sgp_pkg::KIND_PROP && m_axis_tuser != sgp_pkg::KIND_PAY)
	`ASSERT_CLK(a_second_closes, clk, arst_n, push.cnt == 2'd2 |-> (push.res1.kind == sgp_pkg::KIND_END || push.res1.kind == sgp_pkg::KIND_ERR))

endmodule
